// ===== sv/whnp_pkg.sv =====
// Shared types and constants for the watch-hit novelty profiler.
// No dependencies; every other file imports this package.
`default_nettype none
package whnp_pkg;

	localparam int CAPTURE_ENTRIES_DEF    = 64;
	localparam int BACKGROUND_ENTRIES_DEF = 256;

	localparam logic [15:0] SHOT_WINDOW_RST   = 16'd60;
	localparam logic [15:0] BG_WINDOW_RST     = 16'd120;
	localparam logic [15:0] BG_INTERVAL_RST   = 16'd400;
	localparam logic [7:0]  MAX_ROUNDS_RST    = 8'd20;

	localparam logic [15:0] CNT_MAX   = 16'hFFFF;
	localparam logic [15:0] TICK_MAX  = 16'hFFFF;
	localparam logic [7:0]  ROUND_MAX = 8'hFF;

	typedef enum logic [1:0] {
		REG_SHOT_WINDOW = 2'd0,
		REG_BG_WINDOW   = 2'd1,
		REG_BG_INTERVAL = 2'd2,
		REG_MAX_ROUNDS  = 2'd3
	} reg_idx_t;

	localparam logic ACT_HIT  = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam logic KIND_NOVEL = 1'b0;
	localparam logic KIND_NONE  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] hit_address;
		logic        trigger_edge;
		logic        arm_allowed;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] reader_address;
		logic [15:0] hit_count;
		logic [7:0]  shot_round;
		logic [6:0]  readers_in_sample;
		logic [8:0]  background_size;
		logic        tracer_stopped;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] cnt;
	} cap_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic hit_start;
		logic cap_read;
		logic hit_inc;
		logic hit_next;
		logic hit_append;
		logic tick;
		logic bg_start;
		logic bg_read;
		logic bg_hit;
		logic bg_next;
		logic fold;
		logic ci_next;
		logic set_pend;
		logic push;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_hit;
		logic armed;
		logic closing;
		logic shot;
		logic ci_end;
		logic bj_end;
		logic hit_match;
		logic bg_match;
		logic found;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/watch_hit_novelty_profiler_unit.sv =====
// Top level of the watch-hit novelty profiler: sequencer plus datapath.
// Depends on whnp_pkg, whnp_ctrl, whnp_dpath.
//
//  port group  | dir | handshake                 | beat
//  ------------+-----+---------------------------+----------------------------
//  item        | in  | item_valid/item_stall     | hit or millisecond tick
//  result      | out | result_valid/result_stall | one reader report line
//  cfg         | in  | cfg_valid/cfg_ready       | register index + write data
//
// A tick updates the timers and, when a sample closes, starts the close walk.
// A hit searches the capture entries until a match (sequential walk of
// the capture memory, one read port). A closing sample walks every captured
// entry, each one scanning the background memory up to a match or its fill.
// Reset clears all control state; memories carry fill counts, no clearing pass.
// A stalled result holds up the close walk whenever a new result is due (a push or the final line).
`default_nettype none
module watch_hit_novelty_profiler_unit #(
	parameter int CAPTURE_ENTRIES    = whnp_pkg::CAPTURE_ENTRIES_DEF,
	parameter int BACKGROUND_ENTRIES = whnp_pkg::BACKGROUND_ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  whnp_pkg::item_t    item,
	output logic               result_valid,
	input  wire logic          result_stall,
	output whnp_pkg::result_t  result,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);
	import whnp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one item in flight, stall held until its work is done
	whnp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// storage, counters and the output register
	whnp_dpath #(
		.CAPTURE_ENTRIES    (CAPTURE_ENTRIES),
		.BACKGROUND_ENTRIES (BACKGROUND_ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

// ===== sv/whnp_ctrl.sv =====
// Sequencer for the profiler: hit search, tick update, sample close walk.
// Depends on whnp_pkg.
`default_nettype none
module whnp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  whnp_pkg::sts_t     sts,
	output whnp_pkg::cmd_t     cmd
);
	import whnp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_HRD, S_HCMP, S_CRD, S_BRD, S_BCMP, S_DECIDE, S_PUSH, S_FIN
	} state_t;

	state_t state_q, state_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_hit) begin
					if (sts.armed) begin
						cmd.hit_start = 1'b1;
						state_d       = S_HRD;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					cmd.tick = 1'b1;
					state_d  = sts.closing ? S_CRD : S_IDLE;
				end
			end
			S_HRD: begin
				if (sts.ci_end) begin
					cmd.hit_append = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.cap_read = 1'b1;
					state_d      = S_HCMP;
				end
			end
			S_HCMP: begin
				if (sts.hit_match) begin
					cmd.hit_inc = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.hit_next = 1'b1;
					state_d      = S_HRD;
				end
			end
			S_CRD: begin
				if (sts.ci_end) begin
					state_d = sts.shot ? S_FIN : S_IDLE;
				end else begin
					cmd.cap_read = 1'b1;
					cmd.bg_start = 1'b1;
					state_d      = S_BRD;
				end
			end
			S_BRD: begin
				if (sts.bj_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.bg_read = 1'b1;
					state_d     = S_BCMP;
				end
			end
			S_BCMP: begin
				if (sts.bg_match) begin
					cmd.bg_hit = 1'b1;
					state_d    = S_DECIDE;
				end else begin
					cmd.bg_next = 1'b1;
					state_d     = S_BRD;
				end
			end
			S_DECIDE: begin
				if (!sts.shot) begin
					cmd.fold    = 1'b1;
					cmd.ci_next = 1'b1;
					state_d     = S_CRD;
				end else if (sts.found) begin
					cmd.ci_next = 1'b1;
					state_d     = S_CRD;
				end else if (sts.pend_valid) begin
					state_d = S_PUSH;
				end else begin
					cmd.set_pend = 1'b1;
					cmd.ci_next  = 1'b1;
					state_d      = S_CRD;
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.push    = 1'b1;
					cmd.ci_next = 1'b1;
					state_d     = S_CRD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/whnp_dpath.sv =====
// Datapath: config registers, capture and background memories, counters,
// pending result and output register. Depends on whnp_pkg.
`default_nettype none
module whnp_dpath #(
	parameter int CAPTURE_ENTRIES    = whnp_pkg::CAPTURE_ENTRIES_DEF,
	parameter int BACKGROUND_ENTRIES = whnp_pkg::BACKGROUND_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  whnp_pkg::item_t       item,
	input  wire logic             result_stall,
	output logic                  result_valid,
	output whnp_pkg::result_t     result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data,
	input  whnp_pkg::cmd_t        cmd,
	output whnp_pkg::sts_t        sts
);
	import whnp_pkg::*;

	localparam int CIW = $clog2(CAPTURE_ENTRIES);
	localparam int CFW = CIW + 1;
	localparam int BIW = $clog2(BACKGROUND_ENTRIES);
	localparam int BFW = BIW + 1;
	localparam logic [CFW-1:0] CAP_FULL = CFW'(CAPTURE_ENTRIES);
	localparam logic [BFW-1:0] BG_FULL  = BFW'(BACKGROUND_ENTRIES);

	cap_entry_t  cap_mem [CAPTURE_ENTRIES];
	logic [31:0] bg_mem  [BACKGROUND_ENTRIES];

	item_t       item_q;
	cap_entry_t  cap_rd_q;
	logic [31:0] bg_rd_q;
	cap_entry_t  pend_q;
	result_t     out_q;

	logic [15:0]    shot_win_q, bg_win_q, bg_int_q;
	logic [7:0]     max_rounds_q;
	logic [CFW-1:0] cap_fill_q, ci_q;
	logic [BFW-1:0] bg_fill_q, bj_q;
	logic           armed_q, shot_q, bg_started_q, trace_q, stopped_q;
	logic           found_q, pend_valid_q, out_valid_q;
	logic [15:0]    tsa_q, tsb_q;
	logic [7:0]     rounds_q;

	logic [15:0] tsa_inc, tsb_inc, win;
	logic [7:0]  rounds_inc;
	logic        closing, out_free, cap_we, bg_we, bg_cond, bg_arm;
	logic [CIW-1:0] cap_wa;
	cap_entry_t  cap_wd;
	result_t     fin_res, push_res;

	assign tsa_inc    = (tsa_q == TICK_MAX) ? tsa_q : tsa_q + 16'd1;
	assign tsb_inc    = (tsb_q == TICK_MAX) ? tsb_q : tsb_q + 16'd1;
	assign rounds_inc = (rounds_q == ROUND_MAX) ? rounds_q : rounds_q + 8'd1;
	assign win        = shot_q ? shot_win_q : bg_win_q;
	assign closing    = armed_q && (tsa_inc >= win);
	assign bg_cond    = !bg_started_q || (tsb_inc >= bg_int_q);
	assign bg_arm     = !armed_q && !item_q.trigger_edge && bg_cond && trace_q &&
		item_q.arm_allowed;
	assign out_free   = !out_valid_q || !result_stall;

	assign sts.is_hit     = (item_q.action == ACT_HIT);
	assign sts.armed      = armed_q;
	assign sts.closing    = closing;
	assign sts.shot       = shot_q;
	assign sts.ci_end     = (ci_q == cap_fill_q);
	assign sts.bj_end     = (bj_q == bg_fill_q);
	assign sts.hit_match  = (cap_rd_q.addr == item_q.hit_address);
	assign sts.bg_match   = (bg_rd_q == cap_rd_q.addr);
	assign sts.found      = found_q;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// capture write: count bump at the search index or append at the fill
	always_comb begin
		cap_we = 1'b0;
		cap_wa = ci_q[CIW-1:0];
		cap_wd = cap_rd_q;
		if (cmd.hit_inc) begin
			cap_we     = 1'b1;
			cap_wd.cnt = (cap_rd_q.cnt == CNT_MAX) ? CNT_MAX : cap_rd_q.cnt + 16'd1;
		end else if (cmd.hit_append && (cap_fill_q < CAP_FULL)) begin
			cap_we      = 1'b1;
			cap_wa      = cap_fill_q[CIW-1:0];
			cap_wd.addr = item_q.hit_address;
			cap_wd.cnt  = 16'd1;
		end
	end

	assign bg_we = cmd.fold && !found_q && (bg_fill_q < BG_FULL);

	always_comb begin
		push_res                   = '0;
		push_res.result_kind       = KIND_NOVEL;
		push_res.reader_address    = pend_q.addr;
		push_res.hit_count         = pend_q.cnt;
		push_res.shot_round        = rounds_q;
		push_res.readers_in_sample = 7'(cap_fill_q);
		push_res.background_size   = 9'(bg_fill_q);
		push_res.tracer_stopped    = stopped_q;
		push_res.last              = 1'b0;
		fin_res                    = push_res;
		fin_res.last               = 1'b1;
		if (!pend_valid_q) begin
			fin_res.result_kind    = KIND_NONE;
			fin_res.reader_address = '0;
			fin_res.hit_count      = '0;
		end
	end

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (cap_we) cap_mem[cap_wa] <= cap_wd;
		if (cmd.cap_read) cap_rd_q <= cap_mem[ci_q[CIW-1:0]];
		if (bg_we) bg_mem[bg_fill_q[BIW-1:0]] <= cap_rd_q.addr;
		if (cmd.bg_read) bg_rd_q <= bg_mem[bj_q[BIW-1:0]];
		if (cmd.latch) item_q <= item;
		if (cmd.set_pend || cmd.push) pend_q <= cap_rd_q;
		if (cmd.push) out_q <= push_res;
		else if (cmd.fin) out_q <= fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shot_win_q   <= SHOT_WINDOW_RST;
			bg_win_q     <= BG_WINDOW_RST;
			bg_int_q     <= BG_INTERVAL_RST;
			max_rounds_q <= MAX_ROUNDS_RST;
			cap_fill_q   <= '0;
			ci_q         <= '0;
			bg_fill_q    <= '0;
			bj_q         <= '0;
			armed_q      <= 1'b0;
			shot_q       <= 1'b0;
			bg_started_q <= 1'b0;
			trace_q      <= 1'b1;
			stopped_q    <= 1'b0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			tsa_q        <= '0;
			tsb_q        <= '0;
			rounds_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_SHOT_WINDOW: shot_win_q   <= cfg_data;
					REG_BG_WINDOW:   bg_win_q     <= cfg_data;
					REG_BG_INTERVAL: bg_int_q     <= cfg_data;
					REG_MAX_ROUNDS:  max_rounds_q <= cfg_data[7:0];
				endcase
			end
			if (cmd.hit_start || cmd.tick) ci_q <= '0;
			if (cmd.hit_next || cmd.ci_next) ci_q <= ci_q + CFW'(1);
			if (cmd.hit_append && (cap_fill_q < CAP_FULL)) cap_fill_q <= cap_fill_q + CFW'(1);
			if (cmd.bg_start) begin
				bj_q    <= '0;
				found_q <= 1'b0;
			end
			if (cmd.bg_next) bj_q <= bj_q + BFW'(1);
			if (cmd.bg_hit) found_q <= 1'b1;
			if (bg_we) bg_fill_q <= bg_fill_q + BFW'(1);
			if (cmd.tick) begin
				if (!bg_arm) tsb_q <= tsb_inc;
				if (armed_q) begin
					tsa_q <= tsa_inc;
					if (closing) begin
						armed_q      <= 1'b0;
						pend_valid_q <= 1'b0;
						if (shot_q) begin
							rounds_q  <= rounds_inc;
							stopped_q <= (rounds_inc >= max_rounds_q);
						end
					end
				end else if (item_q.trigger_edge) begin
					if (trace_q && item_q.arm_allowed) begin
						armed_q    <= 1'b1;
						shot_q     <= 1'b1;
						cap_fill_q <= '0;
						tsa_q      <= '0;
					end
				end else if (bg_arm) begin
					armed_q      <= 1'b1;
					shot_q       <= 1'b0;
					cap_fill_q   <= '0;
					tsa_q        <= '0;
					tsb_q        <= '0;
					bg_started_q <= 1'b1;
				end
			end
			if (cmd.set_pend) pend_valid_q <= 1'b1;
			if (cmd.fin && stopped_q) trace_q <= 1'b0;
			if (cmd.push || cmd.fin) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
